// ===== src/connection_throttle_table_defines.svh =====
// Assertion helpers shared by the throttle table modules.
// Both expect clk and rst_n in scope.
`ifndef CONNECTION_THROTTLE_TABLE_DEFINES_SVH
`define CONNECTION_THROTTLE_TABLE_DEFINES_SVH

// Property checked on every edge outside reset.
`define CTT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent in this cycle, consequent in the next one.
`define CTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cthr_pkg.sv =====
`timescale 1ns / 1ps
package cthr_pkg;

  localparam int DEF_TABLE_DEPTH = 64;

  localparam int ADDR_W     = 32;
  localparam int REP_W      = 29;
  localparam int HOLD_W     = 32;
  localparam int BASE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 29;

  localparam logic [BASE_W-1:0] BASE_HOLD_RST = 8'd5;
  localparam logic [REP_W-1:0]  COUNT_CAP_RST = 29'd400000000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_HOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_CAP = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input address
    logic clr_scan;  // scan index and keep index to zero
    logic inc_scan;
    logic rd;        // read table at scan index
    logic ld_cnt;    // latch saturated repeat count
    logic ld_prod;   // latch base * count
    logic wr_hit;    // update matched entry, emit refusal
    logic ins_new;   // append entry, emit allow
    logic ld_full;   // emit allow with full flag
    logic wr_keep;   // compaction write of surviving entry
    logic commit;    // entry count takes the keep index
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic match;
    logic hold_nz;
    logic full;
    logic out_free;
  } status_t;

endpackage

// ===== src/cthr_ctrl.sv =====
`timescale 1ns / 1ps
`include "connection_throttle_table_defines.svh"
module cthr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_mode,
  output logic             in_stall,
  output cthr_pkg::cmd_t    cmd,
  input  cthr_pkg::status_t status
);
  import cthr_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_S_RD  = 8'b0000_0010,
    ST_S_CMP = 8'b0000_0100,
    ST_S_MUL = 8'b0000_1000,
    ST_S_HIT = 8'b0001_0000,
    ST_S_MIS = 8'b0010_0000,
    ST_T_RD  = 8'b0100_0000,
    ST_T_CHK = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture  = 1'b1;
          cmd.clr_scan = 1'b1;
          state_nxt    = in_mode ? ST_T_RD : ST_S_RD;
        end
      end
      ST_S_RD: begin
        if (status.scan_done) begin
          state_nxt = ST_S_MIS;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_S_CMP;
        end
      end
      ST_S_CMP: begin
        if (status.match) begin
          cmd.ld_cnt = 1'b1;
          state_nxt  = ST_S_MUL;
        end else begin
          cmd.inc_scan = 1'b1;
          state_nxt    = ST_S_RD;
        end
      end
      ST_S_MUL: begin
        cmd.ld_prod = 1'b1;
        state_nxt   = ST_S_HIT;
      end
      ST_S_HIT: begin
        if (status.out_free) begin
          cmd.wr_hit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_S_MIS: begin
        if (status.out_free) begin
          if (status.full) begin
            cmd.ld_full = 1'b1;
          end else begin
            cmd.ins_new = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_T_RD: begin
        if (status.scan_done) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_T_CHK;
        end
      end
      ST_T_CHK: begin
        cmd.wr_keep  = status.hold_nz;
        cmd.inc_scan = 1'b1;
        state_nxt    = ST_T_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CTT_ASSERT_NEXT(a_tick_starts_sweep, (state_r == ST_IDLE) && in_valid && in_mode, state_r == ST_T_RD, "tick did not start sweep")
  `CTT_ASSERT(a_cmp_follows_rd, (state_r == ST_S_CMP) |-> ($past(state_r) == ST_S_RD), "compare without read")
  `CTT_ASSERT(a_no_insert_when_full, cmd.ins_new |-> !status.full, "insert into full table")

endmodule

// ===== src/cthr_dp.sv =====
`timescale 1ns / 1ps
`include "connection_throttle_table_defines.svh"
module cthr_dp #(
  parameter int TABLE_DEPTH = cthr_pkg::DEF_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cthr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cthr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [cthr_pkg::ADDR_W-1:0]     in_ip_addr,
  input  cthr_pkg::cmd_t                  cmd,
  output cthr_pkg::status_t               status,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_allowed,
  output logic                            out_table_full,
  output logic [cthr_pkg::HOLD_W-1:0]     out_hold_ticks
);
  import cthr_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int PROD_W = BASE_W + REP_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [REP_W-1:0]  rep;
    logic [HOLD_W-1:0] hold;
  } entry_t;

  entry_t mem [TABLE_DEPTH];

  logic [BASE_W-1:0] base_hold_r;
  logic [REP_W-1:0]  count_cap_r;
  logic [CNT_W-1:0]  entry_count_r;
  logic [CNT_W-1:0]  scan_idx_r;
  logic [CNT_W-1:0]  kept_r;
  logic [ADDR_W-1:0] ip_r;
  entry_t            rd_data_r;
  logic [REP_W-1:0]  cnt_r;
  logic [PROD_W-1:0] prod_r;
  logic              out_valid_r;
  logic              out_allowed_r;
  logic              out_table_full_r;
  logic [HOLD_W-1:0] out_hold_r;

  logic [REP_W:0]    cnt_inc;
  logic [REP_W-1:0]  cnt_sat;
  logic [HOLD_W-1:0] hold_sat;
  logic [HOLD_W-1:0] base_ext;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  entry_t            mem_wd;
  logic              out_load;

  assign cnt_inc  = {1'b0, rd_data_r.rep} + {{REP_W{1'b0}}, 1'b1};
  assign cnt_sat  = (cnt_inc > {1'b0, count_cap_r}) ? count_cap_r : cnt_inc[REP_W-1:0];
  assign hold_sat = (|prod_r[PROD_W-1:HOLD_W]) ? '1 : prod_r[HOLD_W-1:0];
  assign base_ext = HOLD_W'(base_hold_r);

  assign status.scan_done = (scan_idx_r == entry_count_r);
  assign status.match     = (rd_data_r.addr == ip_r);
  assign status.hold_nz   = |rd_data_r.hold;
  assign status.full      = (entry_count_r == DEPTH_C);
  assign status.out_free  = !out_valid_r || !out_stall;

  // one write port shared by hit update, append and compaction
  always_comb begin
    mem_we = cmd.wr_hit | cmd.ins_new | cmd.wr_keep;
    mem_wa = scan_idx_r[IDX_W-1:0];
    mem_wd = '{addr: ip_r, rep: cnt_r, hold: hold_sat};
    if (cmd.ins_new) begin
      mem_wa = entry_count_r[IDX_W-1:0];
      mem_wd = '{addr: ip_r, rep: '0, hold: base_ext};
    end else if (cmd.wr_keep) begin
      mem_wa = kept_r[IDX_W-1:0];
      mem_wd = '{addr: rd_data_r.addr, rep: rd_data_r.rep,
                 hold: rd_data_r.hold - {{(HOLD_W-1){1'b0}}, 1'b1}};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_hold_r <= BASE_HOLD_RST;
      count_cap_r <= COUNT_CAP_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_HOLD) begin
        base_hold_r <= cfg_wdata[BASE_W-1:0];
      end else if (cfg_index == CFG_COUNT_CAP) begin
        count_cap_r <= cfg_wdata[REP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
      scan_idx_r    <= '0;
      kept_r        <= '0;
    end else begin
      if (cmd.commit) begin
        entry_count_r <= kept_r;
      end else if (cmd.ins_new) begin
        entry_count_r <= entry_count_r + 1'b1;
      end
      if (cmd.clr_scan) begin
        scan_idx_r <= '0;
      end else if (cmd.inc_scan) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
      if (cmd.clr_scan) begin
        kept_r <= '0;
      end else if (cmd.wr_keep) begin
        kept_r <= kept_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ip_r <= in_ip_addr;
    end
    if (cmd.ld_cnt) begin
      cnt_r <= cnt_sat;
    end
    if (cmd.ld_prod) begin
      prod_r <= PROD_W'(base_hold_r) * PROD_W'(cnt_r);
    end
  end

  // result register
  assign out_load = cmd.wr_hit | cmd.ins_new | cmd.ld_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_allowed_r    <= ~cmd.wr_hit;
      out_table_full_r <= cmd.ld_full;
      out_hold_r       <= cmd.wr_hit ? hold_sat : (cmd.ins_new ? base_ext : '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_allowed    = out_allowed_r;
  assign out_table_full = out_table_full_r;
  assign out_hold_ticks = out_hold_r;

  `CTT_ASSERT(a_count_in_range, entry_count_r <= DEPTH_C, "entry count above depth")
  `CTT_ASSERT(a_keep_behind_scan, kept_r <= scan_idx_r, "compaction overtook scan")
  `CTT_ASSERT(a_load_when_free, out_load |-> status.out_free, "result overwrote pending item")

endmodule

// ===== src/connection_throttle_table.sv =====
`timescale 1ns / 1ps
// Attempt: the table is scanned entry by entry up to the match (all valid entries for a
// new address); with one table read port, each entry takes a read state and a compare state.
// Tick: each valid entry is read, then checked and, if its hold is nonzero, compacted; no result.
// One item at a time; in_stall stays high until the item's work is done.
// Reset: empty table, base_hold = 5, count_cap = 400000000, no result pending.
// The table memory is not cleared; entries beyond the count are never read.
module connection_throttle_table #(
  parameter int TABLE_DEPTH = cthr_pkg::DEF_TABLE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cthr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cthr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [cthr_pkg::ADDR_W-1:0]     in_ip_addr,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_allowed,
  output logic                            out_table_full,
  output logic [cthr_pkg::HOLD_W-1:0]     out_hold_ticks
);
  import cthr_pkg::*;

  cmd_t    cmd;
  status_t status;

  cthr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  cthr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_ip_addr     (in_ip_addr),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_allowed    (out_allowed),
    .out_table_full (out_table_full),
    .out_hold_ticks (out_hold_ticks)
  );

endmodule
